/* src/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes, the result beat type and the register clamp
// functions of the go-back-n sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SEQ_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int IDX_BITS   = 2;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  localparam logic [IDX_BITS-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_TOTAL_PACKETS = 2'd1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [SLOT_BITS-1:0] slot;
    logic                 fin;
    logic                 restart_timer;
    logic                 last;
  } result_t;

  // zero acts as one, anything above the window depth acts as the depth
  function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] w);
    logic [WIN_BITS-1:0] r;
    r = w;
    if (w == '0) r = WIN_BITS'(1);
    else if (w > WIN_BITS'(MAX_WINDOW)) r = WIN_BITS'(MAX_WINDOW);
    return r;
  endfunction

  // zero acts as one, the all-ones sequence acts as all-ones less one
  function automatic logic [SEQ_BITS-1:0] eff_total(input logic [SEQ_BITS-1:0] t);
    logic [SEQ_BITS-1:0] r;
    r = t;
    if (t == '0) r = SEQ_BITS'(1);
    else if (t == '1) r = '1 - SEQ_BITS'(1);
    return r;
  endfunction

endpackage

/* src/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gbn_seq.sv */
// ----------------------------------------------------------------------------
// gbn_seq
// Window sequencer: holds the transfer state, walks the window one beat
// per step and reads or writes the slot sequence memory.
// ----------------------------------------------------------------------------
module gbn_seq import gbn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [1:0]           op,
  input  logic [SEQ_BITS-1:0]  ack_num,
  input  logic                 ack_lost,
  input  logic                 ack_corrupt,
  input  logic [WIN_BITS-1:0]  win,
  input  logic [SEQ_BITS-1:0]  total,
  output logic                 busy,
  input  logic                 out_free,
  output logic                 emit,
  output result_t              res,
  output logic                 mem_we,
  output logic [SLOT_BITS-1:0] mem_waddr,
  output logic [SEQ_BITS-1:0]  mem_wdata,
  output logic [SLOT_BITS-1:0] mem_raddr,
  input  logic [SEQ_BITS-1:0]  mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_NORM    = 7'b0000010,
    S_START   = 7'b0000100,
    S_ACK     = 7'b0001000,
    S_TO_RD   = 7'b0010000,
    S_TO_EMIT = 7'b0100000,
    S_SINGLE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [1:0]           op_r;
  logic [SEQ_BITS-1:0]  ack_r;
  logic                 lost_r, corrupt_r;
  logic [WIN_BITS-1:0]  w;
  logic [SEQ_BITS-1:0]  next_seq;
  logic [SEQ_BITS-1:0]  expected_ack;
  logic [SLOT_BITS-1:0] head_slot;
  logic                 final_sent;
  logic [SEQ_BITS-1:0]  final_ack;
  logic [WIN_BITS-1:0]  cnt;
  logic [WIN_BITS-1:0]  steps;
  logic                 nosend;
  logic [SLOT_BITS-1:0] tslot;
  logic [1:0]           sgl_kind;
  logic                 sgl_restart;

  logic [SEQ_BITS:0]    span;
  logic [WIN_BITS-1:0]  span_steps;
  logic [SLOT_BITS-1:0] head_inc, tslot_inc;
  logic [SEQ_BITS-1:0]  seq_inc;
  logic                 new_fin;
  logic                 step_end;
  logic                 to_stop;

  assign span       = {1'b0, ack_r} - {1'b0, expected_ack} + (SEQ_BITS+1)'(1);
  assign span_steps = (span > (SEQ_BITS+1)'(w)) ? w : WIN_BITS'(span);
  assign head_inc   = (({1'b0, head_slot} + WIN_BITS'(1)) == w) ? '0
                    : head_slot + SLOT_BITS'(1);
  assign tslot_inc  = (({1'b0, tslot} + WIN_BITS'(1)) == w) ? '0
                    : tslot + SLOT_BITS'(1);
  assign seq_inc    = next_seq + SEQ_BITS'(1);
  assign new_fin    = (next_seq == total);
  assign step_end   = (state == S_START) ? (cnt == w - WIN_BITS'(1))
                    : (cnt == steps - WIN_BITS'(1));
  assign to_stop    = (cnt == w - WIN_BITS'(1)) ||
                      (final_sent && ((mem_rdata + SEQ_BITS'(1)) == final_ack));

  assign busy      = (state != S_IDLE);
  assign mem_raddr = tslot;
  assign mem_wdata = next_seq;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    res        = '0;
    mem_we     = 1'b0;
    mem_waddr  = head_slot;
    case (state)
      S_IDLE: begin
        if (go) state_next = S_NORM;
      end
      S_NORM: begin
        if ({1'b0, head_slot} < w) begin
          case (op_r)
            OP_START:   state_next = S_START;
            OP_TIMEOUT: state_next = S_TO_RD;
            OP_ACK: begin
              if (final_sent && ack_r == final_ack) state_next = S_SINGLE;
              else if (!lost_r && !corrupt_r && ack_r >= expected_ack) state_next = S_ACK;
              else state_next = S_SINGLE;
            end
            default: state_next = S_SINGLE;
          endcase
        end
      end
      S_START: begin
        mem_waddr = cnt[SLOT_BITS-1:0];
        if (out_free) begin
          emit              = 1'b1;
          mem_we            = 1'b1;
          res.kind          = KIND_SEND;
          res.seq           = next_seq;
          res.slot          = cnt[SLOT_BITS-1:0];
          res.fin           = new_fin;
          res.restart_timer = 1'b1;
          res.last          = step_end || new_fin;
          if (res.last) state_next = S_IDLE;
        end
      end
      S_ACK: begin
        if (!final_sent) begin
          if (out_free) begin
            emit              = 1'b1;
            mem_we            = 1'b1;
            res.kind          = KIND_SEND;
            res.seq           = next_seq;
            res.slot          = head_slot;
            res.fin           = new_fin;
            res.restart_timer = 1'b1;
            res.last          = step_end || new_fin;
            if (step_end) state_next = S_IDLE;
          end
        end else if (step_end) begin
          state_next = nosend ? S_SINGLE : S_IDLE;
        end
      end
      S_TO_RD: begin
        state_next = S_TO_EMIT;
      end
      S_TO_EMIT: begin
        if (out_free) begin
          emit              = 1'b1;
          res.kind          = KIND_SEND;
          res.seq           = mem_rdata;
          res.slot          = tslot;
          res.fin           = (mem_rdata == total);
          res.restart_timer = 1'b1;
          res.last          = to_stop;
          state_next        = to_stop ? S_IDLE : S_TO_RD;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          emit              = 1'b1;
          res.kind          = sgl_kind;
          res.restart_timer = sgl_restart;
          res.last          = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_seq     <= SEQ_BITS'(1);
      expected_ack <= SEQ_BITS'(2);
      head_slot    <= '0;
      final_sent   <= 1'b0;
      final_ack    <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (go) begin
            op_r      <= op;
            ack_r     <= ack_num;
            lost_r    <= ack_lost;
            corrupt_r <= ack_corrupt;
            w         <= win;
          end
        end
        S_NORM: begin
          cnt   <= '0;
          tslot <= head_slot;
          if ({1'b0, head_slot} >= w) begin
            head_slot <= head_slot - SLOT_BITS'(w);
          end else begin
            sgl_kind    <= (op_r == OP_ACK && final_sent && ack_r == final_ack) ? KIND_DONE
                         : KIND_IDLE;
            sgl_restart <= 1'b0;
            case (op_r)
              OP_START: begin
                next_seq     <= SEQ_BITS'(1);
                expected_ack <= SEQ_BITS'(2);
                head_slot    <= '0;
                final_sent   <= 1'b0;
                final_ack    <= '0;
              end
              OP_ACK: begin
                steps  <= span_steps;
                nosend <= final_sent;
              end
              default: begin
              end
            endcase
          end
        end
        S_START: begin
          if (out_free) begin
            next_seq <= seq_inc;
            cnt      <= cnt + WIN_BITS'(1);
            if (new_fin) begin
              final_sent <= 1'b1;
              final_ack  <= seq_inc;
            end
          end
        end
        S_ACK: begin
          if (final_sent || out_free) begin
            head_slot    <= head_inc;
            expected_ack <= expected_ack + SEQ_BITS'(1);
            cnt          <= cnt + WIN_BITS'(1);
            sgl_restart  <= 1'b1;
            if (!final_sent) begin
              next_seq <= seq_inc;
              if (new_fin) begin
                final_sent <= 1'b1;
                final_ack  <= seq_inc;
              end
            end
          end
        end
        S_TO_EMIT: begin
          if (out_free) begin
            tslot <= tslot_inc;
            cnt   <= cnt + WIN_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/go_back_n_sender_window_top.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Every input beat first passes through the decode state, which repeats and
// wraps the head slot while the window is shrunk to or below it. A start
// beat sends sequences 1 upward into slots 0 upward, one result beat per
// cycle while the output is not stalled, until the window is full or the
// final packet is out. A valid ack beat slides the window one slot per cycle
// while the output is not stalled, sending a beat for each new packet; slots
// slid after the final packet advance without a beat. A timeout beat resends
// from the head slot, each beat taking a read state for the registered read
// of the slot sequence memory and an emit state, until the window or the
// final packet is resent. One input beat is worked on at a time and gives up
// to a window of result beats; the output register lets the next input beat
// in once the sequencer is idle, while the final result beat may still wait.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top import gbn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           op,
  input  logic [SEQ_BITS-1:0]  ack_num,
  input  logic                 ack_lost,
  input  logic                 ack_corrupt,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [1:0]           kind,
  output logic [SEQ_BITS-1:0]  seq,
  output logic [SLOT_BITS-1:0] slot,
  output logic                 fin,
  output logic                 restart_timer,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [SEQ_BITS-1:0]  cfg_data
);

  logic [WIN_BITS-1:0]  win_reg;
  logic [SEQ_BITS-1:0]  total_packets;
  logic                 busy;
  logic                 out_free;
  logic                 emit;
  result_t              res;
  result_t              out_r;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr, mem_raddr;
  logic [SEQ_BITS-1:0]  mem_wdata, mem_rdata;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg       <= WIN_BITS'(4);
      total_packets <= SEQ_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE:   win_reg       <= cfg_data[WIN_BITS-1:0];
        REG_TOTAL_PACKETS: total_packets <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gbn_ram #(
    .WIDTH (SEQ_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gbn_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .go          (item_valid && !item_stall),
    .op          (op),
    .ack_num     (ack_num),
    .ack_lost    (ack_lost),
    .ack_corrupt (ack_corrupt),
    .win         (eff_window(win_reg)),
    .total       (eff_total(total_packets)),
    .busy        (busy),
    .out_free    (out_free),
    .emit        (emit),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign kind          = out_r.kind;
  assign seq           = out_r.seq;
  assign slot          = out_r.slot;
  assign fin           = out_r.fin;
  assign restart_timer = out_r.restart_timer;
  assign last          = out_r.last;

endmodule
